### sv/asrt_pkg.sv
// ---------------------------------------------------------------------------
// Ascending sorter package
// Shared widths, defaults and the command struct that drives the cell chain.
// ---------------------------------------------------------------------------
package asrt_pkg;

   // Width of one sample and of one sorted value.
   localparam int DATA_W = 32;

   // Default number of cells in the chain.
   localparam int CAPACITY_DEF = 16;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic insert;   // place the broadcast sample in sorted position
      logic shift;    // move every value one cell towards the head
   } asrt_cmd_type;

endpackage

### sv/asrt_cell.sv
// ---------------------------------------------------------------------------
// Ascending sorter cell
// Holds one value of the sorted chain. On insert it compares the broadcast
// sample with its own value and either keeps it, takes the sample or takes
// the value of its left neighbour. On shift it takes its right neighbour.
// ---------------------------------------------------------------------------
module asrt_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  asrt_pkg::asrt_cmd_type            cmd,
   input  logic signed [asrt_pkg::DATA_W-1:0] sample,
   input  logic                              left_lt,
   input  logic signed [asrt_pkg::DATA_W-1:0] left_val,
   input  logic                              left_vld,
   input  logic signed [asrt_pkg::DATA_W-1:0] right_val,
   input  logic                              right_vld,
   output logic signed [asrt_pkg::DATA_W-1:0] val,
   output logic                              vld,
   output logic                              lt
);
   import asrt_pkg::*;

   logic signed [DATA_W-1:0] val_ff;
   logic signed [DATA_W-1:0] val_in;
   logic                     vld_ff;
   logic                     vld_in;

   // An empty cell behaves as plus infinity, so the sample goes before it.
   assign lt = !vld_ff || (sample < val_ff);

   // Next value: drain shift, insertion, or hold.
   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      if (cmd.shift) begin
         val_in = right_val;
         vld_in = right_vld;
      end else if (cmd.insert && lt) begin
         if (left_lt) begin
            val_in = left_val;
            vld_in = left_vld;
         end else begin
            val_in = sample;
            vld_in = 1'b1;
         end
      end
   end

   // The valid bit is control state; the value needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      val_ff <= val_in;
   end

   assign val = val_ff;
   assign vld = vld_ff;

endmodule

### sv/ascending_sorter_core.sv
// ---------------------------------------------------------------------------
// Ascending sorter core
// Loads signed samples into a chain of sorting cells, one beat per cycle
// while loading; after the final beat it drains them in ascending order.
// ---------------------------------------------------------------------------
// Load: one request beat per cycle; a sample taken while the chain has room
//   lands in sorted position in the cell chain in the cycle it is accepted
//   (parallel compare per cell). Drain: after the final beat the state
//   register, then the output register, present the first result, then one
//   result per cycle while the consumer keeps up.
// Reset empties the chain and clears the fill count and the drop flag.
module ascending_sorter_core #(
   parameter int CAPACITY = asrt_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [asrt_pkg::DATA_W-1:0] req_sample,
   input  logic                               req_final_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [asrt_pkg::DATA_W-1:0] rsp_ordered_value,
   output logic                               rsp_run_end,
   output logic                               rsp_overflowed
);
   import asrt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         fill_cnt_ff;
   logic [CNT_W-1:0]         remain_ff;
   logic                     drop_ff;
   logic                     run_ovf_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                     rsp_end_ff;
   logic                     rsp_ovf_ff;

   asrt_cmd_type             cmd;
   logic                     req_beat;
   logic                     full;
   logic                     take;

   logic signed [DATA_W-1:0] cell_val [CAPACITY];
   logic [CAPACITY-1:0]      cell_vld;
   logic [CAPACITY-1:0]      cell_lt;

   // Handshake and chain commands.
   assign req_ready  = (state_ff == ST_LOAD);
   assign req_beat   = req_valid && req_ready;
   assign full       = (fill_cnt_ff == CNT_W'(CAPACITY));
   assign take       = (state_ff == ST_DRAIN) && (remain_ff != '0)
                       && (!rsp_valid_ff || rsp_ready);
   assign cmd.insert = req_beat && !full;
   assign cmd.shift  = take;

   // Chain of sorting cells, head at index zero holding the smallest value.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     left_lt;
      logic signed [DATA_W-1:0] left_val;
      logic                     left_vld;
      logic signed [DATA_W-1:0] right_val;
      logic                     right_vld;

      if (i == 0) begin : g_head
         assign left_lt  = 1'b0;
         assign left_val = '0;
         assign left_vld = 1'b0;
      end else begin : g_body_l
         assign left_lt  = cell_lt[i-1];
         assign left_val = cell_val[i-1];
         assign left_vld = cell_vld[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_val = '0;
         assign right_vld = 1'b0;
      end else begin : g_body_r
         assign right_val = cell_val[i+1];
         assign right_vld = cell_vld[i+1];
      end

      asrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sample    (req_sample),
         .left_lt   (left_lt),
         .left_val  (left_val),
         .left_vld  (left_vld),
         .right_val (right_val),
         .right_vld (right_vld),
         .val       (cell_val[i]),
         .vld       (cell_vld[i]),
         .lt        (cell_lt[i])
      );
   end

   // Controller: load counting, drain sequencing and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_cnt_ff  <= '0;
         remain_ff    <= '0;
         drop_ff      <= 1'b0;
         run_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_beat) begin
                  if (req_final_item) begin
                     state_ff    <= ST_DRAIN;
                     remain_ff   <= full ? fill_cnt_ff : fill_cnt_ff + CNT_W'(1);
                     run_ovf_ff  <= drop_ff || full;
                     fill_cnt_ff <= '0;
                     drop_ff     <= 1'b0;
                  end else if (full) begin
                     drop_ff <= 1'b1;
                  end else begin
                     fill_cnt_ff <= fill_cnt_ff + CNT_W'(1);
                  end
               end
            end
            ST_DRAIN: begin
               if (take) begin
                  remain_ff <= remain_ff - CNT_W'(1);
                  if (remain_ff == CNT_W'(1)) begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
      // Result payload, loaded from the head cell as it shifts out.
      if (take) begin
         rsp_value_ff <= cell_val[0];
         rsp_end_ff   <= (remain_ff == CNT_W'(1));
         rsp_ovf_ff   <= run_ovf_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ordered_value = rsp_value_ff;
   assign rsp_run_end       = rsp_end_ff;
   assign rsp_overflowed    = rsp_ovf_ff;

   // The fill count never passes the chain length.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_cnt_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   // Occupied cells match the count the controller keeps.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_vld) == ((state_ff == ST_LOAD) ? int'(fill_cnt_ff)
                                                      : int'(remain_ff)))
      else $error("cell occupancy disagrees with controller count");

   // The end of a run is shown as the last value leaves the chain.
   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      take && (remain_ff == CNT_W'(1)) |=> rsp_valid_ff && rsp_end_ff
         && remain_ff == '0 && state_ff == ST_LOAD)
      else $error("run end shown with values still in the chain");

   // The final beat always starts a drain.
   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_final_item |=> state_ff == ST_DRAIN && remain_ff != '0)
      else $error("final beat did not start a drain");

endmodule
